// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Used by tcw_ctrl, tcw_datapath and text_console_writer; no dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  // Default screen geometry
  localparam int DefColumns = 80;
  localparam int DefRows    = 25;

  // Character codes and cell constants
  localparam logic [7:0]  CH_BACKSPACE = 8'h08;
  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  BLANK_CHAR   = 8'h20;
  localparam logic [7:0]  ATTR_RESET   = 8'h0F;
  localparam logic [15:0] RESET_CELL   = 16'h0F20;

  // Operation codes on the mode input
  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the input fields
    logic execute;     // carry out the captured operation
    logic latch_read;  // take the read data into the result
    logic copy;        // scroll copy step at the pointer
    logic blank;       // write a blank cell at the pointer
    logic init;        // write the reset cell at the pointer
    logic ptr_zero;
    logic ptr_inc;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] mode;
    logic       will_scroll;
    logic       ptr_copy_end;
    logic       ptr_end;
  } dp_sts_t;

endpackage

// ===== rtl/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
// Depends on tcw_pkg for the command and status structs and mode codes.
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             done_o,
  input  tcw_pkg::dp_sts_t sts_i,
  output tcw_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_COPY  = 7'b0010000,
    S_BLANK = 7'b0100000,
    S_DONE  = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  // Accept a new transfer when idle or while the last result is shown
  assign busy   = !((state_q == S_IDLE) || (state_q == S_DONE));
  assign done_o = (state_q == S_DONE);

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        if (sts_i.ptr_end) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_IDLE, S_DONE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        case (sts_i.mode)
          tcw_pkg::MODE_PUT: begin
            if (sts_i.will_scroll) begin
              cmd_o.ptr_zero = 1'b1;
              state_d        = S_COPY;
            end else begin
              state_d = S_DONE;
            end
          end
          tcw_pkg::MODE_CLEAR: begin
            cmd_o.ptr_zero = 1'b1;
            state_d        = S_BLANK;
          end
          tcw_pkg::MODE_READ: begin
            state_d = S_READ;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_READ: begin
        cmd_o.latch_read = 1'b1;
        state_d          = S_DONE;
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        // Pointer stops on the first cell of the bottom row
        if (sts_i.ptr_copy_end) begin
          state_d = S_BLANK;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_BLANK: begin
        cmd_o.blank = 1'b1;
        if (sts_i.ptr_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/tcw_datapath.sv =====
// Datapath of the text console writer: cell memory, cursor, sweep pointer,
// attribute register and result registers. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::DefColumns,
  parameter int ROWS    = tcw_pkg::DefRows
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             attr_we_i,
  input  logic [7:0]       attr_wdata_i,
  input  logic [1:0]       mode_i,
  input  logic [7:0]       char_code_i,
  input  logic [10:0]      cell_address_i,
  output logic [10:0]      cursor_offset_o,
  output logic [15:0]      cell_value_o,
  output logic             scrolled_o,
  input  tcw_pkg::dp_cmd_t cmd_i,
  output tcw_pkg::dp_sts_t sts_o
);

  localparam int Cells   = COLUMNS * ROWS;
  localparam int AW      = $clog2(Cells);
  localparam int CW      = $clog2(COLUMNS);
  localparam int RW      = $clog2(ROWS);
  localparam int CopyEnd = Cells - COLUMNS;

  logic [15:0]   mem [Cells];
  logic [15:0]   rdata_q;

  logic [7:0]    attr_q;
  logic [1:0]    mode_q;
  logic [7:0]    char_q;
  logic [10:0]   addr_q;
  logic [CW-1:0] col_q, col_nx;
  logic [RW-1:0] row_q, row_nx;
  logic [AW-1:0] lin_q, lin_nx;
  logic [AW-1:0] ptr_q;
  logic [15:0]   value_q;
  logic          scrolled_q;

  logic          is_bs, is_nl, row_adv, will_scroll, in_range;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [AW:0]   lin_wide;
  logic [15:0]   blank_cell;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;

  assign blank_cell = {attr_q, tcw_pkg::BLANK_CHAR};
  assign is_bs      = (char_q == tcw_pkg::CH_BACKSPACE) && (col_q != '0);
  assign is_nl      = (char_q == tcw_pkg::CH_NEWLINE);
  assign col_inc    = {1'b0, col_q} + (CW + 1)'(1);
  assign row_inc    = {1'b0, row_q} + (RW + 1)'(1);
  assign in_range   = 32'(addr_q) < 32'(Cells);

  // Cursor after a put: step back, new line, or advance with wrap; scroll when leaving the bottom row
  always_comb begin
    col_nx      = col_q;
    row_nx      = row_q;
    lin_wide    = {1'b0, lin_q};
    row_adv     = 1'b0;
    will_scroll = 1'b0;
    if (is_bs) begin
      col_nx   = col_q - CW'(1);
      lin_wide = {1'b0, lin_q} - (AW + 1)'(1);
    end else if (is_nl) begin
      col_nx   = '0;
      row_adv  = 1'b1;
      lin_wide = {1'b0, lin_q} + (AW + 1)'(COLUMNS) - (AW + 1)'(col_q);
    end else begin
      lin_wide = {1'b0, lin_q} + (AW + 1)'(1);
      if (col_inc == (CW + 1)'(COLUMNS)) begin
        col_nx  = '0;
        row_adv = 1'b1;
      end else begin
        col_nx = col_inc[CW-1:0];
      end
    end
    lin_nx = lin_wide[AW-1:0];
    if (row_adv) begin
      if (row_inc == (RW + 1)'(ROWS)) begin
        will_scroll = 1'b1;
        row_nx      = RW'(ROWS - 1);
        lin_nx      = AW'(CopyEnd);
      end else begin
        row_nx = row_inc[RW-1:0];
      end
    end
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (cmd_i.init) begin
      mem_we    = 1'b1;
      mem_waddr = ptr_q;
      mem_wdata = tcw_pkg::RESET_CELL;
    end else if (cmd_i.blank) begin
      mem_we    = 1'b1;
      mem_waddr = ptr_q;
      mem_wdata = blank_cell;
    end else if (cmd_i.copy) begin
      // Read one row below, write back the cell read in the previous cycle
      mem_re    = (ptr_q != AW'(CopyEnd));
      mem_raddr = AW'({1'b0, ptr_q} + (AW + 1)'(COLUMNS));
      mem_we    = (ptr_q != '0);
      mem_waddr = ptr_q - AW'(1);
      mem_wdata = rdata_q;
    end else if (cmd_i.execute) begin
      case (mode_q)
        tcw_pkg::MODE_PUT: begin
          mem_we    = !is_nl;
          mem_waddr = is_bs ? (lin_q - AW'(1)) : lin_q;
          mem_wdata = is_bs ? blank_cell : {attr_q, char_q};
        end
        tcw_pkg::MODE_READ: begin
          mem_re    = in_range;
          mem_raddr = AW'(addr_q);
        end
        default: begin
          mem_re = 1'b0;
        end
      endcase
    end
  end

  // Cell memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Hold the attribute, cursor and sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
      col_q  <= '0;
      row_q  <= '0;
      lin_q  <= '0;
      ptr_q  <= '0;
    end else begin
      if (attr_we_i) begin
        attr_q <= attr_wdata_i;
      end
      if (cmd_i.execute) begin
        case (mode_q)
          tcw_pkg::MODE_PUT: begin
            col_q <= col_nx;
            row_q <= row_nx;
            lin_q <= lin_nx;
          end
          tcw_pkg::MODE_CLEAR: begin
            col_q <= '0;
            row_q <= '0;
            lin_q <= '0;
          end
          default: begin
            lin_q <= lin_q;
          end
        endcase
      end
      if (cmd_i.ptr_zero) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + AW'(1);
      end
    end
  end

  // Capture the transfer and build the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      char_q <= char_code_i;
      addr_q <= cell_address_i;
    end
    if (cmd_i.execute) begin
      value_q    <= '0;
      scrolled_q <= (mode_q == tcw_pkg::MODE_PUT) && will_scroll;
    end else if (cmd_i.latch_read) begin
      value_q <= in_range ? rdata_q : '0;
    end
  end

  assign sts_o.mode         = mode_q;
  assign sts_o.will_scroll  = will_scroll;
  assign sts_o.ptr_copy_end = (ptr_q == AW'(CopyEnd));
  assign sts_o.ptr_end      = (ptr_q == AW'(Cells - 1));

  assign cursor_offset_o = 11'(lin_q);
  assign cell_value_o    = value_q;
  assign scrolled_o      = scrolled_q;

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
`timescale 1ns / 1ps
//
// Text-mode console with a COLUMNS x ROWS cell memory and a cursor.
// Command channel: a transfer is taken at a clock edge with start high and
// busy low; mode selects put character, clear screen or read one cell.
// Result channel: done_o is high for one cycle with cursor_offset_o,
// cell_value_o and scrolled_o; the receiver cannot stall and must take it.
// Attribute register: written by attr_we_i / attr_wdata_i; the user must
// write it only while idle, the block itself does not enforce this.
// Steps to done_o (a new transfer is taken in the cycle that shows done_o):
//   put without scroll, unused mode : execute, then done
//   read one cell                   : memory read, then latch (registered)
//   clear screen                    : blank every cell, one cell per cycle
//   put that scrolls                : copy one cell per cycle through the
//                                     single memory port pair, then blank
//                                     the bottom row
// After reset the block sweeps the memory to blank spaces with attribute
// 0x0F, holding busy high until the sweep is done.

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DefColumns,
  parameter int ROWS    = tcw_pkg::DefRows
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  char_code_i,
  input  logic [10:0] cell_address_i,
  input  logic        attr_we_i,
  input  logic [7:0]  attr_wdata_i,
  output logic        done_o,
  output logic [10:0] cursor_offset_o,
  output logic [15:0] cell_value_o,
  output logic        scrolled_o
);

  tcw_pkg::dp_cmd_t cmd;
  tcw_pkg::dp_sts_t sts;

  // Sequence each operation
  tcw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Cell memory, cursor and result registers
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .attr_we_i       (attr_we_i),
    .attr_wdata_i    (attr_wdata_i),
    .mode_i          (mode_i),
    .char_code_i     (char_code_i),
    .cell_address_i  (cell_address_i),
    .cursor_offset_o (cursor_offset_o),
    .cell_value_o    (cell_value_o),
    .scrolled_o      (scrolled_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
